// File: rtl/core/gwm_pkg.sv
// gwm_pkg: shared types, constants and register codes for the glob wildcard matcher
// no dependencies; imported by every module under rtl/core
package gwm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int PAT_BYTES       = 32;
  localparam int PAT_WORDS       = 4;
  localparam int LEN_REG_W       = 6;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam int OUT_DATA_W      = 8;

  localparam logic [7:0] STAR_CODE  = 8'h2A;
  localparam logic [7:0] QMARK_CODE = 8'h3F;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_BYTES_0_7      = 3'd1,
    REG_BYTES_8_15     = 3'd2,
    REG_BYTES_16_23    = 3'd3,
    REG_BYTES_24_31    = 3'd4
  } cfg_reg_e;

  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;
  typedef logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_words_t;

  typedef struct packed {
    logic       no_byte;
    logic       end_of_string;
    logic [7:0] subject_byte;
  } item_t;

endpackage

// File: rtl/core/gwm_cfg.sv
// gwm_cfg: pattern length and pattern byte registers behind the plain write port
// depends on gwm_pkg
module gwm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [gwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  output logic [gwm_pkg::LEN_REG_W-1:0]    pat_len,
  output gwm_pkg::pat_bytes_t              pat
);
  import gwm_pkg::*;

  logic [LEN_REG_W-1:0] pattern_length;
  pat_words_t           pattern_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_words  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length   <= cfg_wr_data[LEN_REG_W-1:0];
        REG_BYTES_0_7:      pattern_words[0] <= cfg_wr_data;
        REG_BYTES_8_15:     pattern_words[1] <= cfg_wr_data;
        REG_BYTES_16_23:    pattern_words[2] <= cfg_wr_data;
        REG_BYTES_24_31:    pattern_words[3] <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign pat_len = pattern_length;
  assign pat     = pat_bytes_t'(pattern_words);

endmodule

// File: rtl/core/gwm_closure.sv
// gwm_closure: star closure of a position vector as a log-depth prefix scan
// depends on gwm_pkg
module gwm_closure #(
  parameter int WIDTH = gwm_pkg::MAX_PATTERN_DEF + 1
) (
  input  logic [WIDTH-1:0] vec_in,
  input  logic [WIDTH-1:0] prop,
  output logic [WIDTH-1:0] vec_out
);
  import gwm_pkg::*;

  localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] g [0:LEVELS];
  logic [WIDTH-1:0] p [0:LEVELS];

  // prop[j] set means a live bit at j-1 also sets bit j
  always_comb begin
    g[0] = vec_in;
    p[0] = prop;
    for (int l = 0; l < LEVELS; l++) begin
      g[l+1] = g[l] | (p[l] & (g[l] << (1 << l)));
      p[l+1] = p[l] & (p[l] << (1 << l));
    end
    vec_out = g[LEVELS];
  end

endmodule

// File: rtl/core/gwm_step.sv
// gwm_step: one subject byte step of the position vector, closure before and after
// depends on gwm_pkg and gwm_closure
module gwm_step #(
  parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN:0]          state_vec,
  input  gwm_pkg::item_t                item,
  input  logic [gwm_pkg::LEN_REG_W-1:0] pat_len,
  input  gwm_pkg::pat_bytes_t           pat,
  output logic [MAX_PATTERN:0]          next_vec,
  output logic                          matched
);
  import gwm_pkg::*;

  localparam int VEC_W = MAX_PATTERN + 1;
  localparam int LEN_W = $clog2(VEC_W);

  logic [LEN_W-1:0]       len;
  logic [VEC_W-1:0]       mask;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] step_ok;
  logic [VEC_W-1:0]       prop;
  logic [VEC_W-1:0]       vec_a;
  logic [VEC_W-1:0]       adv;
  logic [VEC_W-1:0]       vec_b;

  always_comb begin
    len = (pat_len > LEN_REG_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len[LEN_W-1:0];
    for (int j = 0; j < VEC_W; j++) begin
      mask[j] = (LEN_W'(j) <= len);
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      star[i]    = (LEN_W'(i) < len) && (pat[i] == STAR_CODE);
      step_ok[i] = (LEN_W'(i) < len) && (pat[i] != STAR_CODE) &&
                   ((pat[i] == QMARK_CODE) || (pat[i] == item.subject_byte));
    end
    prop = {star, 1'b0};
  end

  gwm_closure #(.WIDTH(VEC_W)) u_close_in (
    .vec_in  (state_vec & mask),
    .prop    (prop),
    .vec_out (vec_a)
  );

  // star keeps its position, any other matching byte moves one on
  assign adv = {vec_a[MAX_PATTERN-1:0] & step_ok, 1'b0} |
               {1'b0, vec_a[MAX_PATTERN-1:0] & star};

  gwm_closure #(.WIDTH(VEC_W)) u_close_out (
    .vec_in  (adv),
    .prop    (prop),
    .vec_out (vec_b)
  );

  assign next_vec = item.no_byte ? vec_a : vec_b;
  assign matched  = next_vec[len];

endmodule

// File: rtl/core/glob_wildcard_matcher_top.sv
// glob_wildcard_matcher_top: stream glob matcher with '*' and '?' wildcards
// depends on gwm_pkg, gwm_cfg, gwm_step
//
//  channel  | dir | beat contents (lowest bit up)
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata subject_byte[7:0], tlast end_of_string, tuser no_byte
//  m_axis   | out | tdata matched[0], zeros[7:1]; one beat per end_of_string
//  cfg      | in  | cfg_wr_en, cfg_index, cfg_wr_data; 0 length, 1..4 pattern
//
// one beat per cycle unless stalled; results reach m_axis via the input and output registers
// the next position vector comes combinationally from two prefix scans
// reset clears the pattern registers and returns to the start position
// input stalls only while an end beat waits in the input register behind a
// previous result still held on m_axis
module glob_wildcard_matcher_top #(
  parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // subject_byte
  input  logic                              s_axis_tlast,   // end_of_string
  input  logic                              s_axis_tuser,   // no_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gwm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // matched, zero fill
  input  logic                              cfg_wr_en,
  input  logic [gwm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
  import gwm_pkg::*;

  localparam int VEC_W = MAX_PATTERN + 1;

  logic [LEN_REG_W-1:0] pat_len;
  pat_bytes_t           pat;

  logic                 in_valid;
  item_t                in_item;
  logic [VEC_W-1:0]     state;
  logic [VEC_W-1:0]     state_next;
  logic                 step_matched;
  logic                 out_valid;
  logic                 out_matched;
  logic                 out_free;
  logic                 fire;

  gwm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .pat_len     (pat_len),
    .pat         (pat)
  );

  gwm_step #(.MAX_PATTERN(MAX_PATTERN)) u_step (
    .state_vec (state),
    .item      (in_item),
    .pat_len   (pat_len),
    .pat       (pat),
    .next_vec  (state_next),
    .matched   (step_matched)
  );

  assign out_free      = !out_valid || m_axis_tready;
  assign fire          = in_valid && (!in_item.end_of_string || out_free);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.subject_byte  <= s_axis_tdata;
      in_item.end_of_string <= s_axis_tlast;
      in_item.no_byte       <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= VEC_W'(1);
    end else if (fire) begin
      state <= in_item.end_of_string ? VEC_W'(1) : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_item.end_of_string) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.end_of_string) begin
      out_matched <= step_matched;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_matched};

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.end_of_string |=> m_axis_tvalid)
    else $error("end beat did not produce a result");

  a_end_waits_for_room: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.end_of_string |-> (!out_valid || m_axis_tready))
    else $error("result overwritten before it was taken");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.end_of_string |=> state == VEC_W'(1))
    else $error("position vector not back at start after end beat");

  a_stall_only_on_end: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && in_item.end_of_string && out_valid)
    else $error("input stalled without a held end beat");

endmodule
